/* hw/rtl/fiss_pkg.sv */
// Package: shared constants, types and CRC helpers for the signature scanner.
`default_nettype none
package fiss_pkg;
    localparam int HEADER_BYTES  = 64;
    localparam int PATTERN_BYTES = 6;
    localparam int OFF_W = 48;

    localparam logic [1:0] KIND_LEGACY = 2'd0;
    localparam logic [1:0] KIND_TREE   = 2'd1;
    localparam logic [1:0] KIND_TEXT   = 2'd2;

    localparam logic [2:0] CFG_DEVICE_SIZE = 3'd0;
    localparam logic [2:0] CFG_IMAGE_LIMIT = 3'd1;
    localparam logic [2:0] CFG_TREE_MIN    = 3'd2;
    localparam logic [2:0] CFG_TREE_MAX    = 3'd3;
    localparam logic [2:0] CFG_TEXT_EN     = 3'd4;
    localparam logic [2:0] CFG_TEXT_PAT    = 3'd5;
    localparam logic [2:0] CFG_TEXT_LEN    = 3'd6;

    localparam logic [47:0] TEXT_PAT_RESET = 48'd93652876488564;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    // One hit as it travels from the front to the back part
    typedef struct packed {
        logic [1:0]       kind;
        logic [OFF_W-1:0] offset;
        logic             last;
    } hit_t;

    // One byte step of the reflected CRC-32
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] r;
        r = c ^ {24'd0, d};
        for (int b = 0; b < 8; b++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction
endpackage
`default_nettype wire

/* hw/rtl/fiss_stream_if.sv */
// Interfaces: valid/ready channels for input bytes and hit results.
`default_nettype none
interface fiss_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       device_start;
    modport source (output valid, data_byte, device_start, input ready);
    modport sink   (input valid, data_byte, device_start, output ready);
endinterface

interface fiss_hit_if;
    logic        valid;
    logic        ready;
    logic [1:0]  hit_kind;
    logic [47:0] hit_offset;
    logic        last_hit;
    modport source (output valid, hit_kind, hit_offset, last_hit, input ready);
    modport sink   (input valid, hit_kind, hit_offset, last_hit, output ready);
endinterface
`default_nettype wire

/* hw/rtl/fiss_front.sv */
// Front part: byte window, CRC pipeline and header/text checks, emits hit pairs.
`default_nettype none
module fiss_front #(
    parameter int PATTERN_BYTES = fiss_pkg::PATTERN_BYTES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_start,
    input  wire logic        adv,          // pipeline may move
    input  wire logic [47:0] device_size,
    input  wire logic [31:0] image_data_limit,
    input  wire logic [31:0] tree_min_total,
    input  wire logic [31:0] tree_max_total,
    input  wire logic        text_enable,
    input  wire logic [8*PATTERN_BYTES-1:0] match_pattern,
    input  wire logic [2:0]  text_length,
    output logic             out_valid,    // stage-2 item present
    output fiss_pkg::hit_t   hit_a,
    output logic             hit_a_valid,
    output fiss_pkg::hit_t   hit_b,
    output logic             hit_b_valid
);
    localparam int HB = fiss_pkg::HEADER_BYTES;
    localparam int PB = PATTERN_BYTES;
    localparam int LW = $clog2(PB + 1) > 3 ? $clog2(PB + 1) : 3;

    // Window, oldest byte at index 0; byte count
    logic [7:0]  win_reg [HB];
    logic [47:0] cnt_reg;
    // Running CRC per 4-aligned start: 16 lanes, lane k starts at offset 4k mod 64
    logic [31:0] crc_reg [HB/4];

    logic [47:0] cnt_next;
    logic [7:0]  w [HB];
    logic        take;
    assign take = in_valid && adv;

    always_comb
    begin
        for (int i = 0; i < HB - 1; i++)
            w[i] = in_start ? 8'd0 : win_reg[i+1];
        w[HB-1] = in_byte;
        cnt_next = (in_start ? 48'd0 : cnt_reg) + 48'd1;
    end

    // Offset of the byte just taken; its low six bits give its position within its 64-byte span
    logic [47:0] pos_base;
    assign pos_base = in_start ? 48'd0 : cnt_reg;   // offset of new byte

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            for (int i = 0; i < HB; i++) win_reg[i] <= '0;
            for (int k = 0; k < HB/4; k++) crc_reg[k] <= '1;
        end
        else if (take)
        begin
            cnt_reg <= cnt_next;
            for (int i = 0; i < HB; i++) win_reg[i] <= w[i];
            for (int k = 0; k < HB/4; k++)
            begin
                // rel = byte's position within the span of lane k
                logic [5:0] rel;
                logic [31:0] c;
                rel = pos_base[5:0] - 6'(4*k);
                c = (rel == 6'd0) ? 32'hFFFFFFFF : crc_reg[k];
                if (in_start && pos_base[5:0] != 6'(4*k)) c = 32'hFFFFFFFF;
                crc_reg[k] <= fiss_pkg::crc_byte(c,
                    (rel >= 6'd4 && rel < 6'd8) ? 8'd0 : in_byte);
            end
        end
    end

    // Stage 1 -> stage 2 register: checks use completed window
    logic [3:0]  lane;
    logic [31:0] crc_fin;
    assign lane = cnt_reg[5:2];
    assign crc_fin = crc_reg[lane] ^ 32'hFFFFFFFF;

    function automatic logic [31:0] be(input int p);
        return {win_reg[p], win_reg[p+1], win_reg[p+2], win_reg[p+3]};
    endfunction

    logic s1_valid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s1_valid_reg <= 1'b0;
        else if (adv) s1_valid_reg <= in_valid;
    end

    // Header and text checks on the current window (valid in the cycle after a transfer)
    logic        hdr_ok, leg, tree, txt;
    logic [47:0] off;
    logic [31:0] tot, ver;
    logic [LW-1:0] len;
    always_comb
    begin
        off = cnt_reg - 48'(HB);
        hdr_ok = (cnt_reg >= 48'(HB)) && (off[1:0] == 2'b00);
        leg = hdr_ok && be(0) == 32'h27051956 && crc_fin == be(4)
            && be(12) != 32'd0 && be(12) <= image_data_limit
            && ({1'b0, off} + 49'(HB) + 49'(be(12)) <= {1'b0, device_size});
        tot = be(4);
        ver = be(20);
        tree = hdr_ok && be(0) == 32'hD00DFEED
            && tot >= tree_min_total && tot <= tree_max_total
            && ({1'b0, off} + 49'(tot) <= {1'b0, device_size})
            && be(16) >= 32'd40 && be(16) < tot
            && be(8) < tot && be(12) < tot
            && be(36) != 32'd0 && be(32) != 32'd0
            && {1'b0, be(8)} + {1'b0, be(36)} <= {1'b0, tot}
            && {1'b0, be(12)} + {1'b0, be(32)} <= {1'b0, tot}
            && (ver == 32'd16 || ver == 32'd17) && be(24) <= ver;
        len = (LW'(text_length) > LW'(PB)) ? LW'(PB) : LW'(text_length);
        txt = text_enable && len != '0 && cnt_reg >= 48'(len);
        for (int k = 0; k < PB; k++)
            if (LW'(k) < len
                && win_reg[HB - 32'(len) + k] != match_pattern[8*(PB-1-k) +: 8])
                txt = 1'b0;
    end

    // Stage 2 register: results of the checks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid   <= 1'b0;
            hit_a_valid <= 1'b0;
            hit_b_valid <= 1'b0;
        end
        else if (adv)
        begin
            out_valid   <= s1_valid_reg;
            hit_a_valid <= s1_valid_reg && (leg || tree || txt);
            hit_b_valid <= s1_valid_reg && (leg || tree) && txt;
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_a.kind   <= leg ? fiss_pkg::KIND_LEGACY :
                            tree ? fiss_pkg::KIND_TREE : fiss_pkg::KIND_TEXT;
            hit_a.offset <= (leg || tree) ? off : cnt_reg - 48'(len);
            hit_a.last   <= !((leg || tree) && txt);
            hit_b.kind   <= fiss_pkg::KIND_TEXT;
            hit_b.offset <= cnt_reg - 48'(len);
            hit_b.last   <= 1'b1;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/fiss_back.sv */
// Back part: hit queue that feeds results out one transfer at a time.
`default_nettype none
module fiss_back (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_a,
    input  wire fiss_pkg::hit_t hit_a,
    input  wire logic      push_b,
    input  wire fiss_pkg::hit_t hit_b,
    output logic           room,          // at least six free slots in the queue
    fiss_hit_if.source     hit_out
);
    localparam int DEPTH = 8;
    fiss_pkg::hit_t q_reg [DEPTH];
    logic [2:0] rd_reg, wr_reg;
    logic [3:0] fill_reg;
    logic pop;
    logic [3:0] n_push;

    assign pop = hit_out.valid && hit_out.ready;
    assign n_push = {3'd0, push_a} + {3'd0, push_b};
    // Two item pipeline stages plus this cycle may still deliver hits
    assign room = fill_reg <= 4'(DEPTH - 6);
    assign hit_out.valid      = fill_reg != 4'd0;
    assign hit_out.hit_kind   = q_reg[rd_reg].kind;
    assign hit_out.hit_offset = q_reg[rd_reg].offset;
    assign hit_out.last_hit   = q_reg[rd_reg].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
            wr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            rd_reg <= rd_reg + 3'(pop);
            wr_reg <= wr_reg + 3'(n_push);
            fill_reg <= fill_reg + n_push - 4'(pop);
        end
    end
    always_ff @(posedge clk)
    begin
        if (push_a) q_reg[wr_reg] <= hit_a;
        if (push_b) q_reg[push_a ? wr_reg + 3'd1 : wr_reg] <= hit_b;
    end
endmodule
`default_nettype wire

/* hw/rtl/firmware_image_signature_scanner.sv */
// A byte's hits pass the window and stage-2 result registers before they enter the output queue; stalls can hold them.
// Throughput: one byte per cycle; stalls while more than two hits wait in the queue.
// CRC lanes run one byte per cycle while bytes are taken, one lane per 4-aligned start in the window.
// Reset: async active-low rst_n clears window, count, CRC lanes, valid flags and queue pointers
// and sets config registers to their reset values; hit data and queue entries are not reset.
`default_nettype none
module firmware_image_signature_scanner #(
    parameter int PATTERN_BYTES = fiss_pkg::PATTERN_BYTES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    fiss_byte_if.sink        byte_in,
    fiss_hit_if.source       hit_out,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);
    logic [47:0] device_size_reg;
    logic [31:0] image_data_limit_reg, tree_min_total_reg, tree_max_total_reg;
    logic        text_enable_reg;
    logic [8*PATTERN_BYTES-1:0] match_pattern_reg;
    logic [2:0]  text_length_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_size_reg      <= '0;
            image_data_limit_reg <= 32'd67108864;
            tree_min_total_reg   <= 32'd64;
            tree_max_total_reg   <= 32'd67108864;
            text_enable_reg      <= 1'b0;
            match_pattern_reg    <= (8*PATTERN_BYTES)'(fiss_pkg::TEXT_PAT_RESET);
            text_length_reg      <= 3'd6;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fiss_pkg::CFG_DEVICE_SIZE: device_size_reg <= cfg_data;
                fiss_pkg::CFG_IMAGE_LIMIT: image_data_limit_reg <= cfg_data[31:0];
                fiss_pkg::CFG_TREE_MIN:    tree_min_total_reg <= cfg_data[31:0];
                fiss_pkg::CFG_TREE_MAX:    tree_max_total_reg <= cfg_data[31:0];
                fiss_pkg::CFG_TEXT_EN:     text_enable_reg <= cfg_data[0];
                fiss_pkg::CFG_TEXT_PAT:
                    match_pattern_reg <= (8*PATTERN_BYTES)'(cfg_data);
                fiss_pkg::CFG_TEXT_LEN:    text_length_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    logic room, f_valid, a_v, b_v;
    fiss_pkg::hit_t ha, hb;

    assign byte_in.ready = room;

    fiss_front #(.PATTERN_BYTES(PATTERN_BYTES)) u_front (
        .clk, .rst_n,
        .in_valid(byte_in.valid), .in_byte(byte_in.data_byte),
        .in_start(byte_in.device_start), .adv(room),
        .device_size(device_size_reg), .image_data_limit(image_data_limit_reg),
        .tree_min_total(tree_min_total_reg), .tree_max_total(tree_max_total_reg),
        .text_enable(text_enable_reg), .match_pattern(match_pattern_reg),
        .text_length(text_length_reg),
        .out_valid(f_valid), .hit_a(ha), .hit_a_valid(a_v),
        .hit_b(hb), .hit_b_valid(b_v)
    );

    fiss_back u_back (
        .clk, .rst_n,
        .push_a(a_v && f_valid && room), .hit_a(ha),
        .push_b(b_v && f_valid && room), .hit_b(hb),
        .room, .hit_out
    );
endmodule
`default_nettype wire
